// ----- sv/motor_command_packet_receiver_defines.svh -----
// assertion macros for the motor command packet receiver
// no dependencies; included by the files that carry assertions
`ifndef MOTOR_COMMAND_PACKET_RECEIVER_DEFINES_SVH
`define MOTOR_COMMAND_PACKET_RECEIVER_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define MCPR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("mcpr assertion failed");

// next-cycle implication, disabled while in reset
`define MCPR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("mcpr assertion failed");

`endif

// ----- sv/mcpr_pkg.sv -----
// types and constants for the motor command packet receiver
// no dependencies; imported by motor_command_packet_receiver
package mcpr_pkg;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_RECV = 2'b10
	} rx_state_t;

	localparam logic [1:0] CFG_START_MARKER = 2'd0;
	localparam logic [1:0] CFG_END_MARKER   = 2'd1;
	localparam logic [1:0] CFG_PWM_PERIOD   = 2'd2;

	localparam logic [7:0]  START_MARKER_RST = 8'd247;
	localparam logic [7:0]  END_MARKER_RST   = 8'd255;
	localparam logic [15:0] PWM_PERIOD_RST   = 16'd1000;
	localparam logic [7:0]  DUTY_RST         = 8'd30;

	localparam logic [7:0] WHEEL_STOP = 8'd0;
	localparam logic [7:0] WHEEL_FWD  = 8'd1;
	localparam logic [7:0] WHEEL_BACK = 8'd2;
	localparam logic [7:0] TURN_STRAIGHT = 8'd0;
	localparam logic [7:0] TURN_RIGHT    = 8'd1;
	localparam logic [7:0] TURN_LEFT     = 8'd2;

	localparam logic [1:0] PINS_OFF        = 2'b00;
	localparam logic [1:0] WHEEL_PINS_FWD  = 2'b10;
	localparam logic [1:0] WHEEL_PINS_BACK = 2'b01;
	localparam logic [1:0] TURN_PINS_RIGHT = 2'b01;
	localparam logic [1:0] TURN_PINS_LEFT  = 2'b10;

	localparam logic [2:0] FIRST_INDEX = 3'd1;
	localparam logic [2:0] LAST_INDEX  = 3'd5;

	// divide by 100 as multiply by ceil(2^31/100), exact for 24-bit dividends
	localparam int PROD_W      = 24;
	localparam int RECIP_W     = 25;
	localparam int SCALED_W    = PROD_W + RECIP_W;
	localparam int RECIP_SHIFT = 31;
	localparam int QUO_W       = SCALED_W - RECIP_SHIFT;
	localparam logic [RECIP_W-1:0] RECIP_100 = 25'd21474837;
	localparam logic [QUO_W-1:0]   COMPARE_MAX = 18'd65535;

	typedef struct packed {
		logic       ok;
		logic [1:0] wheel_pins;
		logic [7:0] wheel_duty;
		logic [7:0] wheel_cmd;
		logic [1:0] turn_pins;
		logic [7:0] turn_duty;
		logic [7:0] turn_cmd;
	} result_t;

endpackage

// ----- sv/motor_command_packet_receiver.sv -----
// motor command packet receiver: packet framing, command decode and pwm compare scaling
// depends on mcpr_pkg and motor_command_packet_receiver_defines.svh
`include "motor_command_packet_receiver_defines.svh"

// One received byte is taken per clock while in_stall is low. A packet is the start marker,
// wheel command, wheel duty, turn command, turn amount and end marker; the end marker byte
// produces one result word and every other byte produces none. The result word passes
// three registered stages: the first takes the decoded state with the end byte, the second
// the duty times period multiply and the third the divide by 100, done as a reciprocal
// multiply. The stages advance independently, so bytes keep flowing while a result waits
// on out_stall; in_stall rises only when all three stages hold undelivered results.
// Configuration writes are always ready and take effect at once.
module motor_command_packet_receiver
	import mcpr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        packet_ok,
	output logic [1:0]  wheel_pins,
	output logic [7:0]  wheel_duty_pct,
	output logic [15:0] wheel_compare,
	output logic [7:0]  wheel_cmd_code,
	output logic [1:0]  turn_pins,
	output logic [7:0]  turn_duty_pct,
	output logic [15:0] turn_compare,
	output logic [7:0]  turn_cmd_code,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	logic [7:0]  start_marker_q;
	logic [7:0]  end_marker_q;
	logic [15:0] pwm_period_q;

	rx_state_t   state_q;
	logic [2:0]  byte_index_q;
	logic [7:0]  payload_q [4];
	logic [1:0]  wheel_pin_q;
	logic [1:0]  turn_pin_q;
	logic [7:0]  wheel_duty_q;
	logic [7:0]  turn_duty_q;
	logic [7:0]  wheel_cmd_q;
	logic [7:0]  turn_cmd_q;

	logic        valid_s1, valid_s2, valid_s3;
	result_t     res_s1, res_s2, res_s3;
	logic [PROD_W-1:0] wheel_prod_s2, turn_prod_s2;
	logic [15:0] wheel_cmp_s3, turn_cmp_s3;

	logic        adv1, adv2, adv3;
	logic        accept;
	logic        last_byte;
	logic        end_ok;
	logic [1:0]  wheel_pin_d, turn_pin_d;
	logic [7:0]  wheel_duty_d, turn_duty_d;
	logic [SCALED_W-1:0] wheel_scaled, turn_scaled;
	logic [QUO_W-1:0]    wheel_quo, turn_quo;

	assign adv3     = !valid_s3 || !out_stall;
	assign adv2     = !valid_s2 || adv3;
	assign adv1     = !valid_s1 || adv2;
	assign in_stall = !adv1;
	assign accept   = in_valid && adv1;
	assign cfg_ready = 1'b1;

	assign last_byte = (state_q == ST_RECV) && (byte_index_q == LAST_INDEX);
	assign end_ok    = (rx_byte == end_marker_q);

	always_comb begin
		wheel_pin_d  = wheel_pin_q;
		wheel_duty_d = wheel_duty_q;
		turn_pin_d   = turn_pin_q;
		turn_duty_d  = turn_duty_q;
		case (payload_q[0])
			WHEEL_STOP: begin
				wheel_pin_d  = PINS_OFF;
				wheel_duty_d = 8'd0;
			end
			WHEEL_FWD: begin
				wheel_pin_d  = WHEEL_PINS_FWD;
				wheel_duty_d = payload_q[1];
			end
			WHEEL_BACK: begin
				wheel_pin_d  = WHEEL_PINS_BACK;
				wheel_duty_d = payload_q[1];
			end
			default: begin
			end
		endcase
		case (payload_q[2])
			TURN_STRAIGHT: begin
				turn_pin_d  = PINS_OFF;
				turn_duty_d = 8'd0;
			end
			TURN_RIGHT: begin
				turn_pin_d  = TURN_PINS_RIGHT;
				turn_duty_d = payload_q[3];
			end
			TURN_LEFT: begin
				turn_pin_d  = TURN_PINS_LEFT;
				turn_duty_d = payload_q[3];
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_marker_q <= START_MARKER_RST;
			end_marker_q   <= END_MARKER_RST;
			pwm_period_q   <= PWM_PERIOD_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_START_MARKER: start_marker_q <= cfg_data[7:0];
				CFG_END_MARKER:   end_marker_q   <= cfg_data[7:0];
				CFG_PWM_PERIOD:   pwm_period_q   <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			byte_index_q <= 3'd0;
			wheel_pin_q  <= PINS_OFF;
			turn_pin_q   <= PINS_OFF;
			wheel_duty_q <= DUTY_RST;
			turn_duty_q  <= DUTY_RST;
			wheel_cmd_q  <= WHEEL_STOP;
			turn_cmd_q   <= TURN_STRAIGHT;
		end else if (accept) begin
			case (state_q)
				ST_IDLE: begin
					if (rx_byte == start_marker_q) begin
						state_q      <= ST_RECV;
						byte_index_q <= FIRST_INDEX;
					end
				end
				ST_RECV: begin
					if (byte_index_q != LAST_INDEX) begin
						byte_index_q <= byte_index_q + 3'd1;
					end else begin
						state_q      <= ST_IDLE;
						byte_index_q <= 3'd0;
						if (end_ok) begin
							wheel_pin_q  <= wheel_pin_d;
							turn_pin_q   <= turn_pin_d;
							wheel_duty_q <= wheel_duty_d;
							turn_duty_q  <= turn_duty_d;
							wheel_cmd_q  <= payload_q[0];
							turn_cmd_q   <= payload_q[2];
						end
					end
				end
				default: begin
					state_q      <= ST_IDLE;
					byte_index_q <= 3'd0;
				end
			endcase
		end
	end

	// payload bytes 1 to 4
	always_ff @(posedge clk) begin
		if (accept && (state_q == ST_RECV) && (byte_index_q != LAST_INDEX)) begin
			payload_q[2'(byte_index_q - FIRST_INDEX)] <= rx_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (adv1) valid_s1 <= accept && last_byte;
			if (adv2) valid_s2 <= valid_s1;
			if (adv3) valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			res_s1.ok         <= end_ok;
			res_s1.wheel_pins <= end_ok ? wheel_pin_d : wheel_pin_q;
			res_s1.wheel_duty <= end_ok ? wheel_duty_d : wheel_duty_q;
			res_s1.wheel_cmd  <= end_ok ? payload_q[0] : wheel_cmd_q;
			res_s1.turn_pins  <= end_ok ? turn_pin_d : turn_pin_q;
			res_s1.turn_duty  <= end_ok ? turn_duty_d : turn_duty_q;
			res_s1.turn_cmd   <= end_ok ? payload_q[2] : turn_cmd_q;
		end
		if (adv2) begin
			res_s2        <= res_s1;
			wheel_prod_s2 <= {16'd0, res_s1.wheel_duty} * {8'd0, pwm_period_q};
			turn_prod_s2  <= {16'd0, res_s1.turn_duty} * {8'd0, pwm_period_q};
		end
		if (adv3) begin
			res_s3       <= res_s2;
			wheel_cmp_s3 <= (wheel_quo > COMPARE_MAX) ? 16'hFFFF : wheel_quo[15:0];
			turn_cmp_s3  <= (turn_quo > COMPARE_MAX) ? 16'hFFFF : turn_quo[15:0];
		end
	end

	assign wheel_scaled = SCALED_W'(wheel_prod_s2) * SCALED_W'(RECIP_100);
	assign turn_scaled  = SCALED_W'(turn_prod_s2) * SCALED_W'(RECIP_100);
	assign wheel_quo    = wheel_scaled[SCALED_W-1:RECIP_SHIFT];
	assign turn_quo     = turn_scaled[SCALED_W-1:RECIP_SHIFT];

	assign out_valid      = valid_s3;
	assign packet_ok      = res_s3.ok;
	assign wheel_pins     = res_s3.wheel_pins;
	assign wheel_duty_pct = res_s3.wheel_duty;
	assign wheel_compare  = wheel_cmp_s3;
	assign wheel_cmd_code = res_s3.wheel_cmd;
	assign turn_pins      = res_s3.turn_pins;
	assign turn_duty_pct  = res_s3.turn_duty;
	assign turn_compare   = turn_cmp_s3;
	assign turn_cmd_code  = res_s3.turn_cmd;

	`MCPR_ASSERT_NOW(a_stall_only_when_full, clk, arst_n, in_stall,
		valid_s1 && valid_s2 && valid_s3 && out_stall)
	`MCPR_ASSERT_NEXT(a_last_byte_gives_word, clk, arst_n, accept && last_byte, valid_s1)
	`MCPR_ASSERT_NEXT(a_drop_keeps_state, clk, arst_n, accept && last_byte && !end_ok,
		$stable(wheel_duty_q) && $stable(turn_duty_q) && $stable(wheel_cmd_q) &&
		$stable(turn_cmd_q))
	`MCPR_ASSERT_NOW(a_idle_index_clear, clk, arst_n, state_q == ST_IDLE, byte_index_q == 3'd0)
	`MCPR_ASSERT_NOW(a_pins_exclusive, clk, arst_n, 1'b1,
		$onehot0(wheel_pin_q) && $onehot0(turn_pin_q))

endmodule
